[rtl/sorted_insert_list_unit_defines.svh]
// ----------------------------------------------------------------------------
// sorted insert list assertion macros
// concurrent assertion wrappers used by sorted_insert_list_unit.sv
// ----------------------------------------------------------------------------
`ifndef SORTED_INSERT_LIST_UNIT_DEFINES_SVH
`define SORTED_INSERT_LIST_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define SIL_ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SIL_ASSERT(label, prop, msg) \
    `SIL_ASSERT_CLK(label, i_clk, i_rst_n, prop, msg)
`else
`define SIL_ASSERT_CLK(label, clk, rst_n, prop, msg)
`define SIL_ASSERT(label, prop, msg)
`endif

`endif

[rtl/sil_pkg.sv]
// ----------------------------------------------------------------------------
// sorted insert list package
// widths, types and the order compare shared by the rtl files
// ----------------------------------------------------------------------------
`default_nettype none

package sil_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int VALUE_W       = 32;
    localparam int POS_W         = 4;

    typedef logic signed [VALUE_W-1:0] t_value;
    typedef logic [POS_W-1:0]          t_pos;

    typedef struct packed {
        logic load;
        logic prop;
        logic insert;
        logic rotate;
    } t_cell_cmd;

    // entry must sit after the new value in the current order
    function automatic logic lies_past(input t_value e, input t_value v, input logic desc);
        lies_past = desc ? (e < v) : (e > v);
    endfunction

endpackage

`default_nettype wire

[rtl/sil_in_if.sv]
// ----------------------------------------------------------------------------
// sorted insert list input channel
// valid/ready channel carrying one insert request
// ----------------------------------------------------------------------------
`default_nettype none

interface sil_in_if import sil_pkg::*; ();
    logic   valid;
    logic   ready;
    t_value new_value;
    logic   start_new;

    modport source (output valid, output new_value, output start_new, input ready);
    modport sink   (input valid, input new_value, input start_new, output ready);
endinterface

`default_nettype wire

[rtl/sil_out_if.sv]
// ----------------------------------------------------------------------------
// sorted insert list output channel
// valid/ready channel carrying one readout entry
// ----------------------------------------------------------------------------
`default_nettype none

interface sil_out_if import sil_pkg::*; ();
    logic   valid;
    logic   ready;
    t_pos   position;
    t_value entry_value;
    logic   is_last;
    logic   overflow;

    modport source (output valid, output position, output entry_value,
                    output is_last, output overflow, input ready);
    modport sink   (input valid, input position, input entry_value,
                    input is_last, input overflow, output ready);
endinterface

`default_nettype wire

[rtl/sil_cell.sv]
// ----------------------------------------------------------------------------
// sorted insert list cell
// one list entry with its shift flag, talking only to its two neighbors
// ----------------------------------------------------------------------------
`default_nettype none

module sil_cell import sil_pkg::*; (
    input  wire logic      i_clk,
    input  wire t_cell_cmd i_cmd,
    input  wire t_value    i_new_value,
    input  wire logic      i_desc,
    input  wire logic      i_occupied,
    input  wire t_value    i_below_value,
    input  wire logic      i_below_shift,
    input  wire t_value    i_above_value,
    input  wire logic      i_above_shift,
    output logic           o_shift,
    output t_value         o_value
);

    t_value r_value;
    logic   r_shift;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_shift <= !i_occupied || lies_past(r_value, i_new_value, i_desc);
        end else if (i_cmd.prop) begin
            r_shift <= r_shift && i_above_shift;
        end
        if (i_cmd.insert) begin
            if (i_below_shift) begin
                r_value <= i_below_value;
            end else if (r_shift) begin
                r_value <= i_new_value;
            end
        end else if (i_cmd.rotate) begin
            r_value <= i_above_value;
        end
    end

    assign o_shift = r_shift;
    assign o_value = r_value;

endmodule

`default_nettype wire

[rtl/sorted_insert_list_unit.sv]
// ----------------------------------------------------------------------------
// sorted insert list unit
// keeps up to DEPTH signed values in sorted order and reads the list out
// after every insert request
// ----------------------------------------------------------------------------
// The list lives in a chain of DEPTH cells. A request is accepted in IDLE;
// LOAD compares every entry with the new value, PROP lets the shift flags
// settle from the top of the chain down, INSERT shifts and inserts the value
// unless the list was already full, and READ rotates the chain once around
// and hands out the valid entries from cell 0. Output stalls lengthen the
// readout. The sort order bit (high for descending) is taken from i_cfg_wdata
// when i_cfg_we is high; write it only while i_req.ready is high and no entry
// is pending.
`default_nettype none
`include "sorted_insert_list_unit_defines.svh"

module sorted_insert_list_unit import sil_pkg::*; #(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    sil_in_if.sink        i_req,
    sil_out_if.source     o_res,
    input  wire logic     i_cfg_we,
    input  wire logic     i_cfg_wdata
);

    localparam int KW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_LOAD   = 3'd1;
    localparam logic [2:0] ST_PROP   = 3'd2;
    localparam logic [2:0] ST_INSERT = 3'd3;
    localparam logic [2:0] ST_READ   = 3'd4;

    logic [2:0]    r_state;
    logic [KW-1:0] r_k;
    logic [CW-1:0] r_count;
    logic          r_ovf;
    logic          r_desc;
    t_value        r_new_value;

    logic          r_out_valid;
    t_pos          r_out_pos;
    t_value        r_out_value;
    logic          r_out_last;
    logic          r_out_ovf;

    t_cell_cmd     w_cmd;
    t_value        w_value [DEPTH];
    logic          w_shift [DEPTH];
    logic          w_out_free;
    logic          w_emit;
    logic          w_advance;
    logic [31:0]   w_k_ext;

    assign w_out_free = !r_out_valid || o_res.ready;
    assign w_emit     = (r_state == ST_READ) && (CW'(r_k) < r_count) && w_out_free;
    assign w_advance  = (r_state == ST_READ) && ((CW'(r_k) >= r_count) || w_out_free);
    assign w_k_ext    = 32'(r_k);

    always_comb begin
        w_cmd        = '0;
        w_cmd.load   = (r_state == ST_LOAD);
        w_cmd.prop   = (r_state == ST_PROP);
        w_cmd.insert = (r_state == ST_INSERT) && !r_ovf;
        w_cmd.rotate = w_advance;
    end

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        t_value w_below_value;
        logic   w_below_shift;
        t_value w_above_value;
        logic   w_above_shift;

        if (i == 0) begin : g_bottom
            assign w_below_value = '0;
            assign w_below_shift = 1'b0;
        end else begin : g_mid_below
            assign w_below_value = w_value[i-1];
            assign w_below_shift = w_shift[i-1];
        end

        if (i == DEPTH - 1) begin : g_top
            assign w_above_value = w_value[0];
            assign w_above_shift = 1'b1;
        end else begin : g_mid_above
            assign w_above_value = w_value[i+1];
            assign w_above_shift = w_shift[i+1];
        end

        sil_cell u_cell (
            .i_clk         (i_clk),
            .i_cmd         (w_cmd),
            .i_new_value   (r_new_value),
            .i_desc        (r_desc),
            .i_occupied    (CW'(i) < r_count),
            .i_below_value (w_below_value),
            .i_below_shift (w_below_shift),
            .i_above_value (w_above_value),
            .i_above_shift (w_above_shift),
            .o_shift       (w_shift[i]),
            .o_value       (w_value[i])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_desc <= 1'b0;
        end else if (i_cfg_we) begin
            r_desc <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_k     <= '0;
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_req.valid) begin
                        r_new_value <= i_req.new_value;
                        if (i_req.start_new) begin
                            r_count <= '0;
                        end
                        r_state <= ST_LOAD;
                    end
                end
                ST_LOAD: begin
                    r_ovf   <= (r_count == CW'(DEPTH));
                    r_k     <= '0;
                    r_state <= (DEPTH > 1) ? ST_PROP : ST_INSERT;
                end
                ST_PROP: begin
                    if (r_k == KW'(DEPTH - 2)) begin
                        r_k     <= '0;
                        r_state <= ST_INSERT;
                    end else begin
                        r_k <= r_k + KW'(1);
                    end
                end
                ST_INSERT: begin
                    if (!r_ovf) begin
                        r_count <= r_count + CW'(1);
                    end
                    r_k     <= '0;
                    r_state <= ST_READ;
                end
                ST_READ: begin
                    if (w_advance) begin
                        if (r_k == KW'(DEPTH - 1)) begin
                            r_k     <= '0;
                            r_state <= ST_IDLE;
                        end else begin
                            r_k <= r_k + KW'(1);
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // output register, one readout entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_pos   <= w_k_ext[POS_W-1:0];
            r_out_value <= w_value[0];
            r_out_last  <= (CW'(r_k) + CW'(1) == r_count);
            r_out_ovf   <= r_ovf;
        end
    end

    assign i_req.ready       = (r_state == ST_IDLE);
    assign o_res.valid       = r_out_valid;
    assign o_res.position    = r_out_pos;
    assign o_res.entry_value = r_out_value;
    assign o_res.is_last     = r_out_last;
    assign o_res.overflow    = r_out_ovf;

    `SIL_ASSERT(a_count_bound, r_count <= CW'(DEPTH), "entry count above depth")
    `SIL_ASSERT(a_accept_load, (i_req.valid && i_req.ready) |=> (r_state == ST_LOAD),
                "request not loaded")
    `SIL_ASSERT(a_insert_count, (r_state == ST_INSERT && !r_ovf)
                |=> (r_count == $past(r_count) + CW'(1)), "count not advanced on insert")
    `SIL_ASSERT(a_ovf_full, (r_state == ST_READ && r_ovf) |-> (r_count == CW'(DEPTH)),
                "overflow readout on list that is not full")

endmodule

`default_nettype wire

[bench/tb_sorted_insert_list_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted insert list unit testbench
// sends insert requests with random values and start-new flags, keeps its
// own sorted copy of the list and checks every readout entry in order,
// across both sort orders and several sender and receiver idling patterns
// ----------------------------------------------------------------------------

module tb_sorted_insert_list_unit import sil_pkg::*; ();

    localparam int LIST_DEPTH     = DEPTH_DEFAULT;
    localparam int SETTLE_CYCLES  = 2 * LIST_DEPTH + 8;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_OFF       = 300;

    localparam logic ORDER_ASCENDING  = 1'b0;
    localparam logic ORDER_DESCENDING = 1'b1;

    typedef struct packed {
        t_pos   position;
        t_value entry_value;
        logic   is_last;
        logic   overflow;
    } t_readout;

    class sorted_list_scoreboard;
        t_value      list_q [LIST_DEPTH];
        int unsigned fill;
        logic        descending;
        t_readout    readouts_q [$];
        int unsigned errors;
        int unsigned requests_seen;
        int unsigned readouts_checked;
        int unsigned dropped_requests;

        function new();
            fill             = 0;
            descending       = ORDER_ASCENDING;
            errors           = 0;
            requests_seen    = 0;
            readouts_checked = 0;
            dropped_requests = 0;
        endfunction

        function void set_order(logic desc);
            descending = desc;
        endfunction

        function bit goes_after(t_value e, t_value v);
            return descending ? (e < v) : (e > v);
        endfunction

        function int unsigned pending();
            return readouts_q.size();
        endfunction

        function void note_request(t_value v, logic sn);
            int unsigned j;
            logic        dropped;
            t_readout    r;
            requests_seen++;
            if (sn) begin
                fill = 0;
            end
            dropped = (fill >= LIST_DEPTH);
            if (dropped) begin
                dropped_requests++;
            end else begin
                j = fill;
                while (j > 0 && goes_after(list_q[j-1], v)) begin
                    list_q[j] = list_q[j-1];
                    j--;
                end
                list_q[j] = v;
                fill++;
            end
            for (int k = 0; k < fill; k++) begin
                r.position    = t_pos'(k);
                r.entry_value = list_q[k];
                r.is_last     = (k + 1 == fill);
                r.overflow    = dropped;
                readouts_q.push_back(r);
            end
        endfunction

        function void check_readout(t_readout got);
            t_readout want;
            if (readouts_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected readout, expected none, actual pos %0d value %0d",
                         $time, got.position, got.entry_value);
                return;
            end
            want = readouts_q.pop_front();
            readouts_checked++;
            if (got.position !== want.position) begin
                errors++;
                $display("%0t: position mismatch, expected %0d, actual %0d",
                         $time, want.position, got.position);
            end
            if (got.entry_value !== want.entry_value) begin
                errors++;
                $display("%0t: entry_value mismatch at pos %0d, expected %0d, actual %0d",
                         $time, want.position, want.entry_value, got.entry_value);
            end
            if (got.is_last !== want.is_last) begin
                errors++;
                $display("%0t: is_last mismatch at pos %0d, expected %0b, actual %0b",
                         $time, want.position, want.is_last, got.is_last);
            end
            if (got.overflow !== want.overflow) begin
                errors++;
                $display("%0t: overflow mismatch at pos %0d, expected %0b, actual %0b",
                         $time, want.position, want.overflow, got.overflow);
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_wdata;

    sil_in_if  req_if ();
    sil_out_if res_if ();

    sorted_insert_list_unit #(
        .DEPTH (LIST_DEPTH)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_if),
        .o_res       (res_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    sorted_list_scoreboard sb;
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned hold_cycles;
    int unsigned quiet_cycles;

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // receiver: random stalls plus one long hold-off
    initial begin
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                res_if.ready <= 1'b0;
                hold_cycles--;
            end else begin
                res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quiet_cycles <= 0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                sb.note_request(req_if.new_value, req_if.start_new);
            end
            if (res_if.valid && res_if.ready) begin
                sb.check_readout('{position: res_if.position, entry_value: res_if.entry_value,
                                   is_last: res_if.is_last, overflow: res_if.overflow});
            end
            if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("%0t: watchdog, no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("tb_sorted_insert_list_unit: done, errors");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // returns at the rising edge where the request is taken
    task automatic send_request(input t_value v, input logic sn);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_if.valid     <= 1'b1;
        req_if.new_value <= v;
        req_if.start_new <= sn;
        do @(posedge i_clk); while (!req_if.ready);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        req_if.valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_sort_order(input logic desc);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= desc;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.set_order(desc);
    endtask

    function automatic t_value pick_value();
        case ($urandom_range(9))
            5, 6:    return t_value'(int'($urandom_range(8)) - 4);
            7:       return $urandom_range(1) ? t_value'(32'h7fff_ffff) : t_value'(32'h8000_0000);
            8:       return $urandom_range(1) ? t_value'(32'h7fff_fff0 + $urandom_range(15))
                                              : t_value'(32'h8000_0000 + $urandom_range(15));
            9:       return t_value'(0);
            default: return t_value'($urandom);
        endcase
    endfunction

    task automatic run_random(input int unsigned count);
        int unsigned left;
        int unsigned run_len;
        bit          clean_run;
        left = count;
        while (left > 0) begin
            clean_run = ($urandom_range(9) < 7);
            run_len   = $urandom_range(1, 22);
            if (run_len > left) begin
                run_len = left;
            end
            for (int k = 0; k < run_len; k++) begin
                if (clean_run) begin
                    send_request(pick_value(), k == 0);
                end else begin
                    send_request(pick_value(), $urandom_range(9) == 0);
                end
            end
            left -= run_len;
        end
    endtask

    initial begin
        sb                = new();
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_wdata       = 1'b0;
        req_if.valid      = 1'b0;
        req_if.new_value  = '0;
        req_if.start_new  = 1'b0;
        send_idle_pct     = 0;
        recv_stall_pct    = 0;
        hold_cycles       = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, duplicates, full list, start-new on full list
        set_sort_order(ORDER_ASCENDING);
        send_request(t_value'(0), 1'b1);
        send_request(t_value'(32'h7fff_ffff), 1'b0);
        send_request(t_value'(32'h8000_0000), 1'b0);
        send_request(t_value'(0), 1'b0);
        send_request(t_value'(-1), 1'b0);
        send_request(t_value'(1), 1'b0);
        for (int k = 0; k < LIST_DEPTH - 6; k++) begin
            send_request(pick_value(), 1'b0);
        end
        send_request(t_value'(32'h7fff_ffff), 1'b0);
        send_request(t_value'(32'h8000_0000), 1'b0);
        set_sort_order(ORDER_DESCENDING);
        send_request(t_value'(42), 1'b1);
        send_request(t_value'(5), 1'b0);
        send_request(t_value'(-5), 1'b0);
        send_request(t_value'(32'h7fff_ffff), 1'b0);
        send_request(t_value'(32'h8000_0000), 1'b0);
        send_request(t_value'(-7), 1'b1);
        send_request(t_value'(-7), 1'b0);
        send_request(t_value'(3), 1'b0);

        // order flip on a filled list
        set_sort_order(ORDER_ASCENDING);
        send_request(t_value'(-9), 1'b0);
        send_request(t_value'(4), 1'b0);

        // no idling, with a long receiver hold-off at the start
        set_sort_order(ORDER_ASCENDING);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_cycles    = HOLD_OFF;
        run_random(105);

        // sender idling, with one pause until the list readouts are all in
        set_sort_order(ORDER_DESCENDING);
        send_idle_pct  = 45;
        recv_stall_pct = 0;
        run_random(50);
        wait_drained();
        run_random(55);

        // receiver stalling
        set_sort_order(ORDER_ASCENDING);
        send_idle_pct  = 0;
        recv_stall_pct = 45;
        run_random(105);

        // both sides idling
        set_sort_order(ORDER_DESCENDING);
        send_idle_pct  = 12;
        recv_stall_pct = 12;
        run_random(105);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.pending() != 0) begin
            sb.errors++;
            $display("%0t: %0d readouts never arrived", $time, sb.pending());
        end
        $display("covered %0d requests (%0d dropped on a full list) and %0d readout entries,",
                 sb.requests_seen, sb.dropped_requests, sb.readouts_checked);
        $display("both sort orders, order flips on filled lists and four idling patterns");
        if (sb.errors == 0) begin
            $display("tb_sorted_insert_list_unit: done, clean");
        end else begin
            $display("tb_sorted_insert_list_unit: done, errors");
        end
        $finish;
    end

endmodule

[sorted_insert_list_unit.f]
+incdir+rtl
rtl/sil_pkg.sv
rtl/sil_in_if.sv
rtl/sil_out_if.sv
rtl/sil_cell.sv
rtl/sorted_insert_list_unit.sv
bench/tb_sorted_insert_list_unit.sv
